// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the crossover RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/smc_pkg.sv =====
// ---------------------------------------------------------------------------
// smc_pkg
// Types, constants and saturation helpers of the stereo crossover.
// ---------------------------------------------------------------------------
package smc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEFF_BITS  = 32;
    localparam int SIG_W       = 32;
    localparam int ST_W        = 48;
    localparam int PROD_W      = 64;
    localparam int PROD_SHIFT  = 12;
    localparam int OUT_SHIFT   = COEFF_BITS - 3 - PROD_SHIFT;
    localparam int TERMS       = 5;
    localparam int MAX_BANDS   = 4;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_COEF   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        PH_ISSUE  = 3'd0,
        PH_MUL_B0 = 3'd1,
        PH_Y      = 3'd2,
        PH_ACC1   = 3'd3,
        PH_ACC2   = 3'd4,
        PH_WR_S1  = 3'd5,
        PH_WR_S2  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        DST_BAND = 2'd0,
        DST_REM  = 2'd1,
        DST_LO   = 2'd2,
        DST_SUM  = 2'd3
    } dst_t;

    typedef struct packed {
        logic [1:0]                     command;
        logic signed [SAMPLE_BITS-1:0]  sample_left;
        logic signed [SAMPLE_BITS-1:0]  sample_right;
        logic [6:0]                     coeff_address;
        logic signed [COEFF_BITS-1:0]   coeff_value;
    } smc_in_t;

    typedef struct packed {
        logic [1:0]                     band_index;
        logic signed [SAMPLE_BITS-1:0]  band_left;
        logic signed [SAMPLE_BITS-1:0]  band_right;
        logic                           last_band;
    } smc_out_t;

    typedef struct packed {
        logic       run;
        phase_t     ph;
        logic       first;
        logic       last_stage;
        logic       src_band;
        logic [1:0] src_idx;
        dst_t       dst;
        logic [1:0] dst_idx;
        logic       load_rem;
        logic       clear;
        logic       emit;
        logic [1:0] out_idx;
        logic       out_top;
    } smc_ctrl_t;

    function automatic logic signed [PROD_W-1:0] sat_bits(
        input logic signed [PROD_W-1:0] v,
        input int                       bits
    );
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = (PROD_W'(64'sd1) <<< (bits - 1)) - PROD_W'(64'sd1);
        lo = -hi - PROD_W'(64'sd1);
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/smc_ram.sv =====
// ---------------------------------------------------------------------------
// smc_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module smc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/smc_lane.sv =====
// ---------------------------------------------------------------------------
// smc_lane
// One channel: shared-MAC transposed DF-II biquad engine, filter state RAM
// and the band, remainder and allpass registers.
// ---------------------------------------------------------------------------
module smc_lane #(
    parameter int ST_DEPTH = 96
) (
    input  logic                                      clk,
    input  logic                                      rstn,
    input  smc_pkg::smc_ctrl_t                        ctrl,
    input  logic signed [smc_pkg::SAMPLE_BITS-1:0]    sample,
    input  logic signed [smc_pkg::COEFF_BITS-1:0]     coef,
    input  logic [$clog2(ST_DEPTH)-1:0]               st_raddr,
    input  logic [$clog2(ST_DEPTH)-1:0]               st_waddr,
    output logic signed [smc_pkg::SIG_W-1:0]          band_out
);
    import smc_pkg::*;

    logic [ST_DEPTH-1:0]      valid_reg;
    logic                     vld_q;
    logic                     st_we;
    logic [ST_W-1:0]          st_rdata;
    logic [ST_W-1:0]          st_wdata;

    logic signed [SIG_W-1:0]  x_reg;
    logic signed [SIG_W-1:0]  y_reg;
    logic signed [SIG_W-1:0]  y_next;
    logic signed [SIG_W-1:0]  rem_reg;
    logic signed [SIG_W-1:0]  lo_reg;
    logic signed [SIG_W-1:0]  band_reg [MAX_BANDS];
    logic signed [SIG_W-1:0]  src;
    logic signed [SIG_W-1:0]  mul_op;
    logic signed [ST_W-1:0]   s1_reg;
    logic signed [ST_W-1:0]   s2_reg;
    logic signed [ST_W-1:0]   st_eff;
    logic signed [ST_W-1:0]   t_val;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] fp;
    logic signed [PROD_W-1:0] acc1_reg;
    logic signed [PROD_W-1:0] acc2_reg;
    logic signed [PROD_W-1:0] wr_sat;
    logic signed [PROD_W-1:0] t_sat;
    logic signed [PROD_W-1:0] y_sat;
    logic signed [PROD_W-1:0] sum_sat;

    smc_ram #(
        .WIDTH (ST_W),
        .DEPTH (ST_DEPTH)
    ) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    always_ff @(posedge clk) begin
        if (!rstn) begin
            valid_reg <= '0;
        end else if (ctrl.clear) begin
            valid_reg <= '0;
        end else if (st_we) begin
            valid_reg[st_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        vld_q <= valid_reg[st_raddr];
    end

    always_comb begin
        st_eff    = vld_q ? $signed(st_rdata) : '0;
        src       = ctrl.src_band ? band_reg[ctrl.src_idx] : rem_reg;
        mul_op    = (ctrl.ph == PH_ACC2 || ctrl.ph == PH_WR_S1) ? y_reg : x_reg;
        prod_next = PROD_W'(coef) * PROD_W'(mul_op);
        fp        = prod_reg >>> PROD_SHIFT;
        t_sat     = sat_bits(fp + PROD_W'(s1_reg), ST_W);
        t_val     = t_sat[ST_W-1:0];
        y_sat     = sat_bits(PROD_W'(t_val >>> OUT_SHIFT), SIG_W);
        y_next    = y_sat[SIG_W-1:0];
        wr_sat    = sat_bits((ctrl.ph == PH_WR_S1) ? (acc1_reg - fp) : (acc2_reg - fp), ST_W);
        st_wdata  = wr_sat[ST_W-1:0];
        st_we     = ctrl.run && (ctrl.ph == PH_WR_S1 || ctrl.ph == PH_WR_S2);
        sum_sat   = sat_bits(PROD_W'(lo_reg) + PROD_W'(y_reg), SIG_W);
        band_out  = ctrl.out_top ? rem_reg : band_reg[ctrl.out_idx];
    end

    always_ff @(posedge clk) begin
        if (ctrl.load_rem) begin
            rem_reg <= SIG_W'(sample);
        end
        if (ctrl.run) begin
            prod_reg <= prod_next;
            case (ctrl.ph)
                PH_ISSUE: begin
                    if (ctrl.first) begin
                        x_reg <= src;
                    end
                end
                PH_MUL_B0: begin
                    s1_reg <= st_eff;
                end
                PH_Y: begin
                    s2_reg <= st_eff;
                    y_reg  <= y_next;
                end
                PH_ACC1: begin
                    acc1_reg <= fp + PROD_W'(s2_reg);
                end
                PH_ACC2: begin
                    acc2_reg <= fp;
                end
                PH_WR_S2: begin
                    if (!ctrl.last_stage) begin
                        x_reg <= y_reg;
                    end else begin
                        case (ctrl.dst)
                            DST_BAND: band_reg[ctrl.dst_idx] <= y_reg;
                            DST_REM:  rem_reg <= y_reg;
                            DST_LO:   lo_reg <= y_reg;
                            DST_SUM:  band_reg[ctrl.dst_idx] <= sum_sat[SIG_W-1:0];
                            default:  ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/smc_ctrl.sv =====
// ---------------------------------------------------------------------------
// smc_ctrl
// Sequencer: walks splits, allpass pairs, stages and MAC phases, drives
// coefficient and state addresses for both lanes, then steps band output.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module smc_ctrl #(
    parameter int NUM_SPLITS       = 3,
    parameter int STAGES_PER_CHAIN = 4,
    parameter int CA_W             = 7,
    parameter int ST_AW            = 7
) (
    input  logic                clk,
    input  logic                rstn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          command,
    input  logic                cfg_clear,
    input  logic [1:0]          active,
    input  logic                out_free,
    output smc_pkg::smc_ctrl_t  ctrl,
    output logic [CA_W-1:0]     coef_raddr,
    output logic [ST_AW-1:0]    st_raddr,
    output logic [ST_AW-1:0]    st_waddr
);
    import smc_pkg::*;

    localparam int G_W         = (STAGES_PER_CHAIN > 1) ? $clog2(STAGES_PER_CHAIN) : 1;
    localparam int SPLIT_SLOTS = NUM_SPLITS * 2 * STAGES_PER_CHAIN;

    state_t         state_reg, state_next;
    phase_t         ph_reg, ph_next;
    logic [G_W-1:0] g_reg, g_next;
    logic           kind_reg, kind_next;
    logic           ap_reg, ap_next;
    logic [1:0]     s_reg, s_next;
    logic [1:0]     r_reg, r_next;
    logic [1:0]     k_reg, k_next;
    logic [2:0]     r_inc;
    logic [3:0]     pair;
    logic [2:0]     term;
    int             slot;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= ST_IDLE;
            ph_reg    <= PH_ISSUE;
            g_reg     <= '0;
            kind_reg  <= 1'b0;
            ap_reg    <= 1'b0;
            s_reg     <= '0;
            r_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            g_reg     <= g_next;
            kind_reg  <= kind_next;
            ap_reg    <= ap_next;
            s_reg     <= s_next;
            r_reg     <= r_next;
            k_reg     <= k_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ph_next    = ph_reg;
        g_next     = g_reg;
        kind_next  = kind_reg;
        ap_next    = ap_reg;
        s_next     = s_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        r_inc      = 3'(r_reg) + 3'd1;
        s_ready    = 1'b0;

        ctrl            = '0;
        ctrl.ph         = ph_reg;
        ctrl.first      = (g_reg == '0) && (ph_reg == PH_ISSUE);
        ctrl.last_stage = (g_reg == G_W'(STAGES_PER_CHAIN - 1));
        ctrl.src_band   = ap_reg;
        ctrl.src_idx    = r_reg;
        ctrl.dst_idx    = ap_reg ? r_reg : s_reg;
        ctrl.out_idx    = k_reg;
        ctrl.out_top    = (k_reg == active);
        ctrl.clear      = cfg_clear;
        if (ap_reg) begin
            ctrl.dst = kind_reg ? DST_SUM : DST_LO;
        end else begin
            ctrl.dst = kind_reg ? DST_REM : DST_BAND;
        end

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (cmd_t'(command))
                        CMD_SAMPLE: begin
                            ctrl.load_rem = 1'b1;
                            ph_next   = PH_ISSUE;
                            g_next    = '0;
                            kind_next = 1'b0;
                            ap_next   = 1'b0;
                            s_next    = '0;
                            r_next    = '0;
                            k_next    = '0;
                            state_next = (active == 2'd0) ? ST_EMIT : ST_RUN;
                        end
                        CMD_CLEAR: ctrl.clear = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                ctrl.run = 1'b1;
                if (ph_reg != PH_WR_S2) begin
                    ph_next = phase_t'(ph_reg + 3'd1);
                end else begin
                    ph_next = PH_ISSUE;
                    if (!ctrl.last_stage) begin
                        g_next = g_reg + G_W'(1);
                    end else begin
                        g_next = '0;
                        if (!kind_reg) begin
                            kind_next = 1'b1;
                        end else begin
                            kind_next = 1'b0;
                            if (3'(s_reg) + 3'd1 != 3'(active)) begin
                                s_next = s_reg + 2'd1;
                            end else if (!ap_reg) begin
                                ap_next = 1'b1;
                                r_next  = '0;
                                s_next  = 2'd1;
                                if (active <= 2'd1) begin
                                    state_next = ST_EMIT;
                                    k_next     = '0;
                                end
                            end else begin
                                r_next = r_inc[1:0];
                                s_next = 2'(r_inc + 3'd1);
                                if (r_inc + 3'd1 >= 3'(active)) begin
                                    state_next = ST_EMIT;
                                    k_next     = '0;
                                end
                            end
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    ctrl.emit = 1'b1;
                    if (k_reg == active) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        pair = 4'((4'(s_reg) * (4'(s_reg) - 4'd1)) >> 1) + 4'(r_reg);
        term = (ph_reg > PH_ACC2) ? 3'd0 : 3'(ph_reg);
        if (ap_reg) begin
            slot = SPLIT_SLOTS + ((int'(pair) * 2 + int'(kind_reg)) * STAGES_PER_CHAIN)
                   + int'(g_reg);
        end else begin
            slot = (int'(s_reg) * 2 + int'(kind_reg)) * STAGES_PER_CHAIN + int'(g_reg);
        end
        coef_raddr = CA_W'(((int'(s_reg) * 2 + int'(kind_reg)) * STAGES_PER_CHAIN
                     + int'(g_reg)) * TERMS + int'(term));
        st_raddr   = ST_AW'(slot * 2 + int'(ph_reg == PH_MUL_B0));
        st_waddr   = ST_AW'(slot * 2 + int'(ph_reg == PH_WR_S2));
    end

    `SMC_ASSERT_NOW(a_ap_order, clk, rstn, state_reg == ST_RUN && ap_reg, s_reg > r_reg)
    `SMC_ASSERT_NOW(a_split_range, clk, rstn, state_reg == ST_RUN, s_reg < active)
    `SMC_ASSERT_NEXT(a_emit_done, clk, rstn, ctrl.emit && k_reg == active, state_reg == ST_IDLE)

endmodule

// ===== hw/rtl/smc_merge.sv =====
// ---------------------------------------------------------------------------
// smc_merge
// Combine the two lane results into one band transaction, saturate to the
// sample width and hold it in the output register.
// ---------------------------------------------------------------------------
module smc_merge (
    input  logic                              clk,
    input  logic                              rstn,
    input  smc_pkg::smc_ctrl_t                ctrl,
    input  logic signed [smc_pkg::SIG_W-1:0]  band_l,
    input  logic signed [smc_pkg::SIG_W-1:0]  band_r,
    output logic                              m_valid,
    input  logic                              m_ready,
    output smc_pkg::smc_out_t                 m_data,
    output logic                              out_free
);
    import smc_pkg::*;

    logic      m_valid_reg;
    smc_out_t  m_data_reg;
    smc_out_t  m_data_next;
    logic signed [PROD_W-1:0] sat_l;
    logic signed [PROD_W-1:0] sat_r;

    always_comb begin
        sat_l = sat_bits(PROD_W'(band_l), SAMPLE_BITS);
        sat_r = sat_bits(PROD_W'(band_r), SAMPLE_BITS);
        m_data_next.band_index = ctrl.out_idx;
        m_data_next.band_left  = sat_l[SAMPLE_BITS-1:0];
        m_data_next.band_right = sat_r[SAMPLE_BITS-1:0];
        m_data_next.last_band  = ctrl.out_top;
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (ctrl.emit) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hw/rtl/stereo_multiband_crossover.sv =====
// Schedule: each biquad stage steps each lane's single MAC through PH_ISSUE
//   to PH_WR_S2; a sample runs the split chains, then the allpass pairs, then
//   one band per cycle while the output register is free.
// Throughput: one transaction in flight; left and right lanes run in lockstep.
// Reset: synchronous active-low; split count 3, all filter state reads zero.
// ---------------------------------------------------------------------------
// stereo_multiband_crossover
// LR8 stereo crossover with allpass compensation of the lower bands.
// ---------------------------------------------------------------------------
module stereo_multiband_crossover #(
    parameter int NUM_SPLITS       = 3,
    parameter int STAGES_PER_CHAIN = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  smc_pkg::smc_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output smc_pkg::smc_out_t  m_data,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data
);
    import smc_pkg::*;

    localparam int COEFF_WORDS = NUM_SPLITS * 2 * STAGES_PER_CHAIN * TERMS;
    localparam int PAIR_SLOTS  = (NUM_SPLITS * (NUM_SPLITS - 1)) / 2 + ((NUM_SPLITS == 1) ? 1 : 0);
    localparam int ST_DEPTH    = 2 * (NUM_SPLITS + PAIR_SLOTS) * 2 * STAGES_PER_CHAIN;
    localparam int CA_W        = $clog2(COEFF_WORDS);
    localparam int ST_AW       = $clog2(ST_DEPTH);

    logic [1:0]              active_reg;
    logic [1:0]              active_eff;
    logic                    coef_we;
    logic [CA_W-1:0]         coef_raddr;
    logic [COEFF_BITS-1:0]   coef_rdata;
    logic [ST_AW-1:0]        st_raddr;
    logic [ST_AW-1:0]        st_waddr;
    logic                    out_free;
    smc_ctrl_t               ctrl;
    logic signed [SIG_W-1:0] band_l;
    logic signed [SIG_W-1:0] band_r;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 2'd3;
        end else if (cfg_wr_en) begin
            active_reg <= cfg_wr_data;
        end
    end

    assign active_eff = (32'(active_reg) < NUM_SPLITS) ? active_reg : 2'(NUM_SPLITS);
    assign coef_we    = s_valid && s_ready && (cmd_t'(s_data.command) == CMD_COEF)
                        && (32'(s_data.coeff_address) < COEFF_WORDS);

    smc_ram #(
        .WIDTH (COEFF_BITS),
        .DEPTH (COEFF_WORDS)
    ) u_coef_ram (
        .clk   (aclk),
        .we    (coef_we),
        .waddr (CA_W'(s_data.coeff_address)),
        .wdata (s_data.coeff_value),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    smc_ctrl #(
        .NUM_SPLITS       (NUM_SPLITS),
        .STAGES_PER_CHAIN (STAGES_PER_CHAIN),
        .CA_W             (CA_W),
        .ST_AW            (ST_AW)
    ) u_ctrl (
        .clk        (aclk),
        .rstn       (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .command    (s_data.command),
        .cfg_clear  (cfg_wr_en),
        .active     (active_eff),
        .out_free   (out_free),
        .ctrl       (ctrl),
        .coef_raddr (coef_raddr),
        .st_raddr   (st_raddr),
        .st_waddr   (st_waddr)
    );

    smc_lane #(
        .ST_DEPTH (ST_DEPTH)
    ) u_lane_left (
        .clk      (aclk),
        .rstn     (aresetn),
        .ctrl     (ctrl),
        .sample   (s_data.sample_left),
        .coef     ($signed(coef_rdata)),
        .st_raddr (st_raddr),
        .st_waddr (st_waddr),
        .band_out (band_l)
    );

    smc_lane #(
        .ST_DEPTH (ST_DEPTH)
    ) u_lane_right (
        .clk      (aclk),
        .rstn     (aresetn),
        .ctrl     (ctrl),
        .sample   (s_data.sample_right),
        .coef     ($signed(coef_rdata)),
        .st_raddr (st_raddr),
        .st_waddr (st_waddr),
        .band_out (band_r)
    );

    smc_merge u_merge (
        .clk      (aclk),
        .rstn     (aresetn),
        .ctrl     (ctrl),
        .band_l   (band_l),
        .band_r   (band_r),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .out_free (out_free)
    );

endmodule

// ===== sim/stereo_multiband_crossover_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// stereo_multiband_crossover_test
// Self-checking bench for the stereo crossover. It loads the coefficients,
// steps the split count through every setting, and sends directed and random
// transactions with random idling on both channels. Each band is checked
// against a bit-exact predictor of the cascaded biquad chains.
// ---------------------------------------------------------------------------
module stereo_multiband_crossover_test;
    import smc_pkg::*;

    class crossover_scoreboard;
        localparam int N_SPLIT = 3;
        localparam int N_STAGE = 4;
        localparam int N_COEF = N_SPLIT * 2 * N_STAGE * TERMS;

        longint coef_mem[N_COEF];
        longint split_st[N_SPLIT][2][2][N_STAGE][2];
        longint pair_st[N_SPLIT][2][2][N_STAGE][2];
        int split_count;
        smc_out_t band_queue[$];
        int errors;
        int samples_seen;
        int bands_checked;

        function new();
            foreach (coef_mem[i]) coef_mem[i] = 0;
            split_count = 3;
            errors = 0;
            samples_seen = 0;
            bands_checked = 0;
            clear_state();
        endfunction

        function void clear_state();
            foreach (split_st[a, b, c, d, e]) split_st[a][b][c][d][e] = 0;
            foreach (pair_st[a, b, c, d, e]) pair_st[a][b][c][d][e] = 0;
        endfunction

        function void set_count(logic [1:0] value);
            split_count = value;
            clear_state();
        endfunction

        function longint sat(longint v, int bits);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        // Run one biquad chain; pair_sel picks the compensation state bank.
        function longint run_biquads(longint x, int split, int kind, int ch,
                                     bit pair_sel, int slot);
            longint t;
            longint y;
            longint s1;
            longint s2;
            int base;
            for (int g = 0; g < N_STAGE; g++) begin
                base = ((split * 2 + kind) * N_STAGE + g) * TERMS;
                s1 = pair_sel ? pair_st[slot][kind][ch][g][0] : split_st[split][kind][ch][g][0];
                s2 = pair_sel ? pair_st[slot][kind][ch][g][1] : split_st[split][kind][ch][g][1];
                t = sat(((coef_mem[base] * x) >>> PROD_SHIFT) + s1, 48);
                y = sat(t >>> OUT_SHIFT, 32);
                s1 = sat(((coef_mem[base + 1] * x) >>> PROD_SHIFT)
                         - ((coef_mem[base + 3] * y) >>> PROD_SHIFT) + s2, 48);
                s2 = sat(((coef_mem[base + 2] * x) >>> PROD_SHIFT)
                         - ((coef_mem[base + 4] * y) >>> PROD_SHIFT), 48);
                if (pair_sel) begin
                    pair_st[slot][kind][ch][g][0] = s1;
                    pair_st[slot][kind][ch][g][1] = s2;
                end else begin
                    split_st[split][kind][ch][g][0] = s1;
                    split_st[split][kind][ch][g][1] = s2;
                end
                x = y;
            end
            return x;
        endfunction

        function void note_input(smc_in_t it);
            longint band[N_SPLIT + 1][2];
            longint rem;
            longint v;
            int active;
            smc_out_t res;
            case (cmd_t'(it.command))
                CMD_COEF: begin
                    if (it.coeff_address < N_COEF)
                        coef_mem[it.coeff_address] = longint'(it.coeff_value);
                end
                CMD_CLEAR: clear_state();
                CMD_SAMPLE: begin
                    active = split_count < N_SPLIT ? split_count : N_SPLIT;
                    samples_seen++;
                    for (int ch = 0; ch < 2; ch++) begin
                        rem = ch == 0 ? longint'(it.sample_left) : longint'(it.sample_right);
                        for (int s = 0; s < active; s++) begin
                            band[s][ch] = run_biquads(rem, s, 0, ch, 0, 0);
                            rem = run_biquads(rem, s, 1, ch, 0, 0);
                        end
                        band[active][ch] = rem;
                        for (int r = 0; r < active; r++) begin
                            v = band[r][ch];
                            for (int s = r + 1; s < active; s++) begin
                                v = sat(run_biquads(v, s, 0, ch, 1, s * (s - 1) / 2 + r)
                                        + run_biquads(v, s, 1, ch, 1, s * (s - 1) / 2 + r), 32);
                            end
                            band[r][ch] = v;
                        end
                    end
                    for (int k = 0; k <= active; k++) begin
                        res.band_index = 2'(k);
                        res.band_left = 24'(sat(band[k][0], SAMPLE_BITS));
                        res.band_right = 24'(sat(band[k][1], SAMPLE_BITS));
                        res.last_band = (k == active);
                        band_queue.push_back(res);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(smc_out_t got);
            smc_out_t want;
            if (band_queue.size() == 0) begin
                $display("%0t: unexpected band, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = band_queue.pop_front();
            bands_checked++;
            if (got.band_index !== want.band_index) begin
                $display("%0t: band_index expected %0d actual %0d", $time, want.band_index,
                         got.band_index);
                errors++;
            end
            if (got.band_left !== want.band_left) begin
                $display("%0t: band_left expected %0d actual %0d", $time, want.band_left,
                         got.band_left);
                errors++;
            end
            if (got.band_right !== want.band_right) begin
                $display("%0t: band_right expected %0d actual %0d", $time, want.band_right,
                         got.band_right);
                errors++;
            end
            if (got.last_band !== want.last_band) begin
                $display("%0t: last_band expected %0d actual %0d", $time, want.last_band,
                         got.last_band);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 3000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    smc_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    smc_out_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_data = '0;

    crossover_scoreboard sb = new();
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int cycles = 0;
    int sent = 0;

    stereo_multiband_crossover dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Check on the pre-edge handshake, then pick the next ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 33);
        end
    end

    task automatic send_item(smc_in_t it);
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        sent++;
        if (!calm && $urandom_range(0, 99) < 33) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.band_queue.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_count(logic [1:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_count(value);
        @(posedge aclk);
    endtask

    function automatic smc_in_t make_coef(int addr, logic [31:0] value);
        smc_in_t it;
        it = '0;
        it.command = CMD_COEF;
        it.coeff_address = 7'(addr);
        it.coeff_value = value;
        it.sample_left = 24'($urandom);
        it.sample_right = 24'($urandom);
        return it;
    endfunction

    function automatic smc_in_t make_sample(logic [23:0] l, logic [23:0] r);
        smc_in_t it;
        it = '0;
        it.command = CMD_SAMPLE;
        it.sample_left = l;
        it.sample_right = r;
        it.coeff_address = 7'($urandom);
        it.coeff_value = $urandom;
        return it;
    endfunction

    function automatic logic [31:0] gentle_coef();
        return $urandom_range(0, 1) ? 32'($signed($urandom_range(0, 1 << 29)) - (1 << 28))
                                    : 32'($urandom);
    endfunction

    function automatic smc_in_t random_item();
        smc_in_t it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            if ($urandom_range(0, 3) == 0) begin
                it = make_sample($urandom_range(0, 1) ? 24'h7fffff : 24'h800000,
                                 $urandom_range(0, 1) ? 24'h7fffff : 24'h800000);
            end else begin
                it = make_sample(24'($urandom), 24'($urandom));
            end
        end else if (pick < 88) begin
            it = make_coef(int'($urandom_range(0, 127)), gentle_coef());
        end else if (pick < 94) begin
            it = make_sample(24'($urandom), 24'($urandom));
            it.command = CMD_CLEAR;
        end else begin
            it = make_sample(24'($urandom), 24'($urandom));
            it.command = CMD_NOP;
        end
        return it;
    endfunction

    initial begin
        logic [1:0] counts[5];
        smc_in_t it;
        counts = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd3};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_count(2'd3);
        for (int a = 0; a < 120; a++) send_item(make_coef(a, gentle_coef()));

        // Directed: field extremes, every command, ignored address.
        send_item(make_sample(24'h7fffff, 24'h800000));
        send_item(make_sample(24'h800000, 24'h7fffff));
        send_item(make_sample(24'h000000, 24'hffffff));
        send_item(make_coef(0, 32'h7fffffff));
        send_item(make_coef(119, 32'h80000000));
        send_item(make_sample(24'h7fffff, 24'h7fffff));
        send_item(make_coef(120, 32'h12345678));
        send_item(make_coef(127, 32'hffffffff));
        send_item(make_sample(24'h800000, 24'h800000));
        it = make_sample(24'h123456, 24'h654321);
        it.command = CMD_CLEAR;
        send_item(it);
        send_item(make_sample(24'h400000, 24'hc00000));
        it.command = CMD_NOP;
        send_item(it);
        send_item(make_coef(0, 32'h20000000));
        send_item(make_coef(119, 32'h00000000));
        send_item(make_sample(24'h000001, 24'hfffffe));

        for (int p = 0; p < 5; p++) begin
            write_count(counts[p]);
            for (int n = 0; n < 39; n++) begin
                if (p == 1 && n == 10) hold_req = 1'b1;
                if (p == 2 && n == 30) drain();
                calm = (p == 3 && n >= 12 && n < 36);
                send_item(random_item());
            end
            calm = 1'b0;
        end

        s_valid <= 1'b0;
        while (sb.band_queue.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("Sent %0d transactions, %0d stereo samples, %0d bands checked",
                 sent, sb.samples_seen, sb.bands_checked);
        $display("Split counts 3, 0, 1, 2, 3 covered; %0d mismatches", sb.errors);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
